// ===== rtl/core/osat_pkg.sv =====
// Shared types and constants for the occupancy summed-area table.
`timescale 1ns / 1ps
`default_nettype none
package osat_pkg;
    localparam int MAX_GRID_W = 128;
    localparam int MAX_GRID_H = 128;
    localparam int GRID_DEPTH = MAX_GRID_W * MAX_GRID_H;
    localparam int SUM_STRIDE = MAX_GRID_W + 1;
    localparam int SUM_DEPTH  = SUM_STRIDE * (MAX_GRID_H + 1);
    localparam int GA_W = $clog2(GRID_DEPTH);
    localparam int SA_W = $clog2(SUM_DEPTH);
    localparam int CW = $clog2(MAX_GRID_W + 1);
    localparam int RW = $clog2(MAX_GRID_H + 1);
    localparam int CNT_W = 15;
    localparam int PC_W = 14;
    localparam int QDEPTH = 4;
    localparam int QA_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Classified work handed from front to back.
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'b001,
        OP_CELL    = 3'b010,
        OP_QUERY   = 3'b100
    } t_op;

    typedef struct packed {
        t_op          op;
        logic         cell_we;   // cell lands inside grid
        logic [CW-1:0] cell_c;
        logic [RW-1:0] cell_r;
        logic         bit_val;
        logic         rebuild;   // last cell of patch
        logic [CW-1:0] c0;       // origin col or query left
        logic [RW-1:0] r0;       // origin row or query top
        logic [CW-1:0] c1;       // query right (exclusive)
        logic [RW-1:0] r1;       // query bottom (exclusive)
        logic         ok;        // query in range
        logic [CW-1:0] gw;
        logic [RW-1:0] gh;
    } t_work;
endpackage
`default_nettype wire

// ===== rtl/core/osat_front.sv =====
// Front end: classifies requests, tracks patch position, checks query range.
`timescale 1ns / 1ps
`default_nettype none
module osat_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [6:0]        i_col,
    input  wire logic [6:0]        i_row,
    input  wire logic [7:0]        i_rect_w,
    input  wire logic [7:0]        i_rect_h,
    input  wire logic              i_occupied,
    input  wire logic [7:0]        i_grid_width,
    input  wire logic [7:0]        i_grid_height,
    output osat_pkg::t_work        o_work,
    output logic                   o_push,
    output logic                   o_busy
);
    import osat_pkg::*;

    logic [PC_W-1:0] r_k, n_k;
    // patch position of r_k for patch width r_kw, advanced incrementally
    logic [7:0]      r_co, n_co;
    logic [PC_W-1:0] r_ro, n_ro;
    logic [7:0]      r_kw, n_kw;
    // request held while its position is found by division
    logic            r_div, n_div, r_fin, n_fin;
    logic [1:0]      r_lcmd;
    logic [6:0]      r_lcol, r_lrow;
    logic [7:0]      r_lrw, r_lrh;
    logic            r_locc;
    logic [PC_W-1:0] r_dvd, n_dvd, r_quo, n_quo;
    logic [7:0]      r_rem, n_rem;
    logic [3:0]      r_dcnt, n_dcnt;
    logic [8:0]      dtry;
    logic            use_l, fast_ok, hold, act;
    logic [1:0]      a_cmd;
    logic [6:0]      a_col, a_row;
    logic [7:0]      a_rw, a_rh;
    logic            a_occ;
    logic [8:0]      gw9, gh9, pw, ph, c_abs, qx2, qy2;
    logic [PC_W:0]   r_abs;
    logic [17:0]     area;
    logic            last;
    t_work           w;

    always_comb begin
        // take the held request while dividing or finishing, else the ports
        use_l = r_div || r_fin;
        a_cmd = use_l ? r_lcmd : i_cmd;
        a_col = use_l ? r_lcol : i_col;
        a_row = use_l ? r_lrow : i_row;
        a_rw  = use_l ? r_lrw  : i_rect_w;
        a_rh  = use_l ? r_lrh  : i_rect_h;
        a_occ = use_l ? r_locc : i_occupied;

        gw9 = (i_grid_width == 8'd0) ? 9'd1 :
              ({1'b0, i_grid_width} > 9'(MAX_GRID_W)) ? 9'(MAX_GRID_W) : {1'b0, i_grid_width};
        gh9 = (i_grid_height == 8'd0) ? 9'd1 :
              ({1'b0, i_grid_height} > 9'(MAX_GRID_H)) ? 9'(MAX_GRID_H) : {1'b0, i_grid_height};
        pw = (a_rw == 8'd0) ? 9'd1 : ({1'b0, a_rw} > 9'd128) ? 9'd128 : {1'b0, a_rw};
        ph = (a_rh == 8'd0) ? 9'd1 : ({1'b0, a_rh} > 9'd128) ? 9'd128 : {1'b0, a_rh};
        c_abs = {2'b0, a_col} + {1'b0, r_co};
        r_abs = {8'b0, a_row} + {1'b0, r_ro};
        qx2 = {2'b0, a_col} + {1'b0, a_rw};
        qy2 = {2'b0, a_row} + {1'b0, a_rh};
        area = pw * ph;
        last = ({4'b0, r_k} + 18'd1) >= area;
        w = '0;
        w.gw = CW'(gw9);
        w.gh = RW'(gh9);
        w.c0 = CW'(a_col);
        w.r0 = RW'(a_row);
        w.c1 = CW'(qx2);
        w.r1 = RW'(qy2);
        w.cell_c = CW'(c_abs);
        w.cell_r = RW'(r_abs);
        w.bit_val = a_occ;
        w.cell_we = (r_ro < PC_W'(ph)) && (r_abs < (PC_W+1)'(gh9)) && (c_abs < gw9);
        w.rebuild = last;
        w.ok = (a_rw != 8'd0) && (a_rh != 8'd0) && (qx2 <= gw9) && (qy2 <= gh9);
        unique case (t_cmd'(a_cmd))
            CMD_CLEAR: w.op = OP_CLEAR;
            CMD_WRITE: w.op = OP_CELL;
            default:   w.op = OP_QUERY;
        endcase
        o_work = w;

        // stored position fits this width, or the counter is at zero
        fast_ok = (r_k == '0) || ({1'b0, r_kw} == pw);
        hold    = i_take && (i_cmd == CMD_WRITE) && !fast_ok;
        act     = r_fin || (i_take && !hold);
        o_push  = act && (a_cmd != CMD_NONE);
        o_busy  = use_l;

        n_k = r_k; n_co = r_co; n_ro = r_ro; n_kw = r_kw;
        n_div = r_div; n_fin = 1'b0;
        n_dvd = r_dvd; n_quo = r_quo; n_rem = r_rem; n_dcnt = r_dcnt;
        dtry = {r_rem, r_dvd[PC_W-1]};

        // start a restoring division of the counter by the patch width
        if (hold) begin
            n_div = 1'b1; n_dvd = r_k; n_quo = '0; n_rem = '0; n_dcnt = '0;
        end
        // one quotient bit per cycle
        if (r_div) begin
            if (dtry >= pw) begin
                n_rem = 8'(dtry - pw);
                n_quo = {r_quo[PC_W-2:0], 1'b1};
            end else begin
                n_rem = dtry[7:0];
                n_quo = {r_quo[PC_W-2:0], 1'b0};
            end
            n_dvd  = {r_dvd[PC_W-2:0], 1'b0};
            n_dcnt = r_dcnt + 4'd1;
            if (r_dcnt == 4'(PC_W - 1)) begin
                n_div = 1'b0; n_fin = 1'b1;
                n_co = n_rem; n_ro = n_quo; n_kw = pw[7:0];
            end
        end

        // advance patch counter
        if (act && a_cmd == CMD_CLEAR) begin
            n_k = '0; n_co = '0; n_ro = '0;
        end else if (act && a_cmd == CMD_WRITE) begin
            if (last) begin
                n_k = '0; n_co = '0; n_ro = '0;
            end else begin
                n_k = r_k + PC_W'(1);
                n_kw = pw[7:0];
                if ({1'b0, r_co} + 9'd1 >= pw) begin
                    n_co = '0;
                    n_ro = r_ro + PC_W'(1);
                end else begin
                    n_co = r_co + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0; r_co <= '0; r_ro <= '0; r_kw <= '0;
            r_div <= 1'b0; r_fin <= 1'b0;
            r_dvd <= '0; r_quo <= '0; r_rem <= '0; r_dcnt <= '0;
        end else begin
            r_k <= n_k; r_co <= n_co; r_ro <= n_ro; r_kw <= n_kw;
            r_div <= n_div; r_fin <= n_fin;
            r_dvd <= n_dvd; r_quo <= n_quo; r_rem <= n_rem; r_dcnt <= n_dcnt;
        end
        // hold the request that waits for its division
        if (hold) begin
            r_lcmd <= i_cmd; r_lcol <= i_col; r_lrow <= i_row;
            r_lrw <= i_rect_w; r_lrh <= i_rect_h; r_locc <= i_occupied;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/osat_queue.sv =====
// Short FIFO of classified work between front and back.
`timescale 1ns / 1ps
`default_nettype none
module osat_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire osat_pkg::t_work i_work,
    input  wire logic           i_pop,
    output osat_pkg::t_work     o_work,
    output logic                o_empty,
    output logic                o_full
);
    import osat_pkg::*;

    t_work r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_work  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QA_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QA_W'(1);
            if (i_pop)  r_rp <= r_rp + QA_W'(1);
            r_cnt <= r_cnt + (QA_W+1)'(i_push) - (QA_W+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/osat_back.sv =====
// Back end: grid and table memories, clear sweep, rebuild walk, query reads.
`timescale 1ns / 1ps
`default_nettype none
module osat_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire osat_pkg::t_work i_work,
    input  wire logic          i_avail,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_is_empty,
    output logic [14:0]        o_box_count,
    output logic               o_in_range
);
    import osat_pkg::*;

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_RS0  = 11'b00000000100,   // row start: read diag table(i, c0)
        S_RS1  = 11'b00000001000,   // row start: read left table(i+1, c0)
        S_RB0  = 11'b00000010000,   // read table(i, j+1) and grid(i, j)
        S_RB1  = 11'b00000100000,   // combine and write table(i+1, j+1)
        S_Q0   = 11'b00001000000,
        S_Q1   = 11'b00010000000,
        S_Q2   = 11'b00100000000,
        S_Q3   = 11'b01000000000,
        S_Q4   = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    logic [CNT_W-1:0] r_sum [SUM_DEPTH];
    logic             r_grid [GRID_DEPTH];
    logic [SA_W-1:0]  r_clr, n_clr;
    logic [CW-1:0] r_j, n_j, r_c0, n_c0, r_gw, n_gw, r_c1, n_c1;
    logic [RW-1:0] r_i, n_i, r_gh, n_gh, r_r1, n_r1, r_r0, n_r0;
    logic [CNT_W-1:0] r_left, n_left;   // table(i+1, j), running along the row
    logic [CNT_W-1:0] r_diag, n_diag;   // table(i, j)
    logic [CNT_W-1:0] r_rd, r_acc, n_acc, r_q, n_q;
    logic             r_gbit;
    // memory port controls
    logic             s_we, g_we, g_wv;
    logic [SA_W-1:0]  s_wa, s_ra;
    logic [CNT_W-1:0] s_wd;
    logic [GA_W-1:0]  g_wa, g_ra;
    logic             r_first, n_first;
    logic             r_val, n_val, r_ok, n_ok;

    function automatic logic [SA_W-1:0] sa(input logic [RW-1:0] r, input logic [CW-1:0] c);
        sa = SA_W'(r) * SA_W'(SUM_STRIDE) + SA_W'(c);
    endfunction

    // memories
    always_ff @(posedge i_clk) begin
        if (s_we) r_sum[s_wa] <= s_wd;
        r_rd <= r_sum[s_ra];
    end
    always_ff @(posedge i_clk) begin
        if (g_we) r_grid[g_wa] <= g_wv;
        r_gbit <= r_grid[g_ra];
    end

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_j = r_j; n_i = r_i; n_c0 = r_c0; n_gw = r_gw;
        n_gh = r_gh; n_c1 = r_c1; n_r1 = r_r1; n_r0 = r_r0; n_acc = r_acc;
        n_first = r_first; n_left = r_left; n_diag = r_diag;
        n_val = 1'b0; n_ok = r_ok; n_q = r_q;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        g_we = 1'b0; g_wa = '0; g_wv = 1'b0; g_ra = '0;
        o_pop = 1'b0;
        unique case (r_st)
            S_CLR: begin
                // sweep both stores one entry a cycle
                s_we = 1'b1; s_wa = r_clr;
                g_we = (r_clr < SA_W'(GRID_DEPTH)); g_wa = GA_W'(r_clr);
                n_clr = r_clr + SA_W'(1);
                if (r_clr == SA_W'(SUM_DEPTH - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    unique case (i_work.op)
                        OP_CLEAR: begin
                            n_clr = '0; n_st = S_CLR;
                        end
                        OP_CELL: begin
                            g_we = i_work.cell_we;
                            g_wa = GA_W'(i_work.cell_r) * GA_W'(MAX_GRID_W)
                                   + GA_W'(i_work.cell_c);
                            g_wv = i_work.bit_val;
                            n_i = i_work.r0; n_j = i_work.c0; n_c0 = i_work.c0;
                            n_gw = i_work.gw; n_gh = i_work.gh;
                            if (i_work.rebuild && i_work.r0 < i_work.gh
                                && i_work.c0 < i_work.gw) n_st = S_RS0;
                        end
                        OP_QUERY: begin
                            n_r0 = i_work.r0; n_c0 = i_work.c0;
                            n_r1 = i_work.r1; n_c1 = i_work.c1; n_ok = i_work.ok;
                            n_st = S_Q0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RS0: begin
                s_ra = sa(r_i, r_j);
                n_st = S_RS1;
            end
            S_RS1: begin
                s_ra = sa(r_i + RW'(1), r_j);
                n_diag = r_rd;
                n_first = 1'b1;
                n_st = S_RB0;
            end
            S_RB0: begin
                // at row start the left value arrives now
                s_ra = sa(r_i, r_j + CW'(1));
                g_ra = GA_W'(r_i) * GA_W'(MAX_GRID_W) + GA_W'(r_j);
                if (r_first) n_left = r_rd;
                n_first = 1'b0;
                n_st = S_RB1;
            end
            S_RB1: begin
                s_we = 1'b1; s_wa = sa(r_i + RW'(1), r_j + CW'(1));
                s_wd = r_rd + r_left - r_diag + CNT_W'(r_gbit);
                n_left = s_wd; n_diag = r_rd;
                if (r_j + CW'(1) >= r_gw) begin
                    n_j = r_c0;
                    n_i = r_i + RW'(1);
                    n_st = (r_i + RW'(1) >= r_gh) ? S_IDLE : S_RS0;
                end else begin
                    n_j = r_j + CW'(1);
                    n_st = S_RB0;
                end
            end
            // four table reads; skip addressing when out of range
            S_Q0: begin
                s_ra = r_ok ? sa(r_r1, r_c1) : '0;
                n_st = S_Q1;
            end
            S_Q1: begin
                s_ra = r_ok ? sa(r_r0, r_c1) : '0;
                n_acc = r_rd; n_st = S_Q2;
            end
            S_Q2: begin
                s_ra = r_ok ? sa(r_r1, r_c0) : '0;
                n_acc = r_acc - r_rd; n_st = S_Q3;
            end
            S_Q3: begin
                s_ra = r_ok ? sa(r_r0, r_c0) : '0;
                n_acc = r_acc - r_rd; n_st = S_Q4;
            end
            S_Q4: begin
                n_q = r_acc + r_rd; n_val = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_val <= 1'b0; r_ok <= 1'b0; r_q <= '0;
        end else begin
            r_st <= n_st; r_clr <= n_clr; r_val <= n_val; r_ok <= n_ok; r_q <= n_q;
        end
        r_j <= n_j; r_i <= n_i; r_c0 <= n_c0; r_gw <= n_gw; r_gh <= n_gh;
        r_c1 <= n_c1; r_r1 <= n_r1; r_r0 <= n_r0; r_acc <= n_acc;
        r_first <= n_first; r_left <= n_left; r_diag <= n_diag;
    end

    assign o_valid     = r_val;
    assign o_box_count = r_ok ? r_q : '0;
    assign o_in_range  = r_ok;
    assign o_is_empty  = r_ok && (r_q == '0);
endmodule
`default_nettype wire

// ===== rtl/core/occupancy_summed_area_table.sv =====
// Top level: occupancy grid with summed-area table and box-sum queries.
// A request is taken when start is high and busy low. When a cell write's
// patch width differs from the width the patch counter was advanced under (and
// the counter is not zero), the front first finds the cell position by a
// 14-step division and holds busy meanwhile. A query is popped by the back
// end, reads the table four times through its one read port, and its result
// is registered onto o_valid after the last read. A patch's last cell starts
// a rebuild from the origin to the grid corner: each table entry takes a read
// state and a write state, and each row begins with two row-start reads.
// After reset and after a clear, a sweep over all (MAX_GRID_W+1)*(MAX_GRID_H+1)
// = 16641 table entries zeroes both stores. A four-entry queue lets requests
// flow during a rebuild or sweep; busy rises when it fills. Query results
// appear for one cycle on o_valid and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_summed_area_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [6:0]  i_col,
    input  wire logic [6:0]  i_row,
    input  wire logic [7:0]  i_rect_w,
    input  wire logic [7:0]  i_rect_h,
    input  wire logic        i_occupied,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    output logic             o_is_empty,
    output logic [14:0]      o_box_count,
    output logic             o_in_range
);
    import osat_pkg::*;

    logic [7:0] r_gw, r_gh;
    t_work fw, qw;
    logic push, pop, q_empty, q_full, f_busy, take;

    // hold config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 8'd128; r_gh <= 8'd128;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_gw <= i_cfg_data;
            else r_gh <= i_cfg_data;
        end
    end

    // hold requests off while the queue is full or the front is dividing
    assign busy = q_full || f_busy;
    assign take = start && !busy;

    osat_front u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_cmd, .i_col, .i_row, .i_rect_w,
        .i_rect_h, .i_occupied, .i_grid_width(r_gw), .i_grid_height(r_gh),
        .o_work(fw), .o_push(push), .o_busy(f_busy)
    );
    osat_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_work(fw), .i_pop(pop),
        .o_work(qw), .o_empty(q_empty), .o_full(q_full)
    );
    osat_back u_back (
        .i_clk, .i_rst_n, .i_work(qw), .i_avail(!q_empty), .o_pop(pop),
        .o_valid, .o_is_empty, .o_box_count, .o_in_range
    );
endmodule
`default_nettype wire

// ===== rtl/core/osat_checker.sv =====
// Port-level checks for the occupancy summed-area table.
`timescale 1ns / 1ps
`default_nettype none
module osat_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        o_is_empty,
    input wire logic [14:0] o_box_count,
    input wire logic        o_in_range
);
    a_empty_needs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_in_range) else $error("empty out of range");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_box_count == 15'd0) else $error("empty count");
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range |-> o_box_count == 15'd0 && !o_is_empty)
        else $error("out of range count");
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
    a_handshake_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({start, busy})) else $error("handshake unknown");
endmodule
bind occupancy_summed_area_table osat_checker u_osat_checker (.*);
`default_nettype wire

// ===== tb/occupancy_summed_area_table_tb.sv =====
// Testbench for the occupancy summed-area table: directed table, random requests, predictor.
`timescale 1ns / 1ps
module occupancy_summed_area_table_tb;
    import osat_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int SUMS_ROW    = MAX_GRID_W + 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [6:0]  i_col;
    logic [6:0]  i_row;
    logic [7:0]  i_rect_w;
    logic [7:0]  i_rect_h;
    logic        i_occupied;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        o_valid;
    logic        o_is_empty;
    logic [14:0] o_box_count;
    logic        o_in_range;

    typedef struct packed {
        logic        is_empty;
        logic [14:0] box_count;
        logic        in_range;
    } t_box;

    typedef struct {
        t_cmd        cmd;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [7:0]  rw;
        logic [7:0]  rh;
        logic        occ;
        logic        typed;
        t_box        want;
    } t_req_row;

    // Shadow copy of the block's stores and registers
    logic        occ_grid[GRID_DEPTH];
    logic [14:0] box_sums[SUM_DEPTH];
    int          cell_count;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;

    t_box pending_boxes[$];
    int   mismatches;
    int   stall_cycles;
    bit   no_gaps;

    occupancy_summed_area_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_col(i_col), .i_row(i_row), .i_rect_w(i_rect_w),
        .i_rect_h(i_rect_h), .i_occupied(i_occupied), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_is_empty(o_is_empty), .o_box_count(o_box_count), .o_in_range(o_in_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_dim(int v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int grid_w();
        return eff_dim(width_reg, MAX_GRID_W);
    endfunction

    function automatic int grid_h();
        return eff_dim(height_reg, MAX_GRID_H);
    endfunction

    function automatic void wipe_stores();
        foreach (occ_grid[i]) occ_grid[i] = 1'b0;
        foreach (box_sums[i]) box_sums[i] = '0;
        cell_count = 0;
    endfunction

    // Recompute prefix sums from the patch origin to the grid corner
    function automatic void rebuild_sums(int r0, int c0);
        int gw;
        int gh;
        gw = grid_w();
        gh = grid_h();
        for (int i = r0; i < gh; i++)
            for (int j = c0; j < gw; j++)
                box_sums[(i + 1) * SUMS_ROW + j + 1] = box_sums[i * SUMS_ROW + j + 1]
                    + box_sums[(i + 1) * SUMS_ROW + j] - box_sums[i * SUMS_ROW + j]
                    + 15'(occ_grid[i * MAX_GRID_W + j]);
    endfunction

    function automatic void write_cell(int col, int row, int rw, int rh, logic occ);
        int w;
        int h;
        int ro;
        int co;
        w  = eff_dim(rw, 128);
        h  = eff_dim(rh, 128);
        ro = cell_count / w;
        co = cell_count % w;
        if (ro < h && row + ro < grid_h() && col + co < grid_w())
            occ_grid[(row + ro) * MAX_GRID_W + col + co] = occ;
        if (cell_count + 1 >= w * h) begin
            rebuild_sums(row, col);
            cell_count = 0;
        end else begin
            cell_count = (cell_count + 1) & 16'h3FFF;
        end
    endfunction

    function automatic t_box box_query(int col, int row, int rw, int rh);
        t_box b;
        logic [14:0] n;
        b = '0;
        if (rw != 0 && rh != 0 && col + rw <= grid_w() && row + rh <= grid_h()) begin
            n = box_sums[(row + rh) * SUMS_ROW + col + rw] - box_sums[row * SUMS_ROW + col + rw]
                - box_sums[(row + rh) * SUMS_ROW + col] + box_sums[row * SUMS_ROW + col];
            b.box_count = n;
            b.in_range  = 1'b1;
            b.is_empty  = (n == 0);
        end
        return b;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (no_gaps || r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one request, hold until accepted, then update the shadow state
    task automatic issue(t_cmd c, int col, int row, int rw, int rh, logic occ,
                         logic typed = 1'b0, t_box want = '0);
        int gap;
        t_box b;
        start      <= 1'b1;
        i_cmd      <= c;
        i_col      <= 7'(col);
        i_row      <= 7'(row);
        i_rect_w   <= 8'(rw);
        i_rect_h   <= 8'(rh);
        i_occupied <= occ;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (c)
            CMD_CLEAR: wipe_stores();
            CMD_WRITE: write_cell(col, row, rw, rh, occ);
            CMD_QUERY: begin
                b = box_query(col, row, rw, rh);
                pending_boxes.push_back(typed ? want : b);
            end
            default: ;
        endcase
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain results and let a rebuild or clear sweep finish
    task automatic settle();
        int pause;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_boxes.size() != 0 || busy) @(posedge i_clk);
        pause = (grid_w() + 1) * (grid_h() + 1) * 6 + 17000;
        repeat (pause) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
        @(posedge i_clk);
    endtask

    // One random phase under the current grid size
    task automatic random_phase(int n_items);
        int done;
        int r;
        int gw;
        int gh;
        int lo;
        int w;
        int h;
        int c;
        int rr;
        gw   = grid_w();
        gh   = grid_h();
        lo   = (gw == 128 && gh == 128) ? 96 : 0;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // well-formed patch with random bits
                w  = $urandom_range(0, 4);
                h  = $urandom_range(0, 4);
                c  = (lo > 0) ? $urandom_range(lo, 127) : $urandom_range(0, gw);
                rr = (lo > 0) ? $urandom_range(lo, 127) : $urandom_range(0, gh);
                if (c > 127) c = 127;
                if (rr > 127) rr = 127;
                for (int k = 0; k < eff_dim(w, 128) * eff_dim(h, 128); k++) begin
                    issue(CMD_WRITE, c, rr, w, h, $urandom_range(0, 1));
                    done++;
                end
            end else if (r < 80) begin
                c  = $urandom_range(0, gw - 1);
                rr = $urandom_range(0, gh - 1);
                issue(CMD_QUERY, c, rr, $urandom_range(1, gw - c),
                      $urandom_range(1, gh - rr), 1'b0);
                done++;
            end else if (r < 90) begin
                issue(CMD_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
                done++;
            end else if (r < 97) begin
                // stray patch cell that may break the sequence
                c  = (lo > 0) ? $urandom_range(lo, 127) : $urandom_range(0, 127);
                rr = (lo > 0) ? $urandom_range(lo, 127) : $urandom_range(0, 127);
                issue(CMD_WRITE, c, rr, $urandom_range(0, 255), $urandom_range(0, 3),
                      $urandom_range(0, 1));
                done++;
            end else if (r < 99) begin
                issue(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
            end else begin
                issue(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
                done++;
            end
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_box got;
        t_box want;
        if (i_rst_n && o_valid) begin
            got = {o_is_empty, o_box_count, o_in_range};
            if (pending_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: empty=%0d count=%0d in_range=%0d",
                             o_is_empty, o_box_count, o_in_range);
            end else begin
                want = pending_boxes.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("box mismatch: exp empty=%0d count=%0d in_range=%0d, got %0d %0d %0d",
                                 want.is_empty, want.box_count, want.in_range,
                                 o_is_empty, o_box_count, o_in_range);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    t_req_row directed[] = '{
        '{CMD_QUERY, 7'd0,   7'd0,   8'd128, 8'd128, 1'b0, 1'b1, '{1'b1, 15'd0, 1'b1}},
        '{CMD_QUERY, 7'd0,   7'd0,   8'd0,   8'd5,   1'b0, 1'b1, '{1'b0, 15'd0, 1'b0}},
        '{CMD_QUERY, 7'd3,   7'd3,   8'd4,   8'd0,   1'b0, 1'b1, '{1'b0, 15'd0, 1'b0}},
        '{CMD_QUERY, 7'd127, 7'd0,   8'd2,   8'd1,   1'b0, 1'b1, '{1'b0, 15'd0, 1'b0}},
        '{CMD_QUERY, 7'd0,   7'd127, 8'd255, 8'd255, 1'b1, 1'b1, '{1'b0, 15'd0, 1'b0}},
        '{CMD_NONE,  7'd127, 7'd127, 8'd255, 8'd255, 1'b1, 1'b0, '0},
        '{CMD_WRITE, 7'd127, 7'd127, 8'd1,   8'd1,   1'b1, 1'b0, '0},
        '{CMD_QUERY, 7'd127, 7'd127, 8'd1,   8'd1,   1'b0, 1'b0, '0},
        '{CMD_WRITE, 7'd126, 7'd126, 8'd2,   8'd2,   1'b1, 1'b0, '0},
        '{CMD_WRITE, 7'd126, 7'd126, 8'd2,   8'd2,   1'b0, 1'b0, '0},
        '{CMD_WRITE, 7'd126, 7'd126, 8'd2,   8'd2,   1'b1, 1'b0, '0},
        '{CMD_WRITE, 7'd126, 7'd126, 8'd2,   8'd2,   1'b1, 1'b0, '0},
        '{CMD_QUERY, 7'd126, 7'd126, 8'd2,   8'd2,   1'b0, 1'b0, '0},
        '{CMD_WRITE, 7'd0,   7'd127, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        '{CMD_WRITE, 7'd127, 7'd120, 8'd2,   8'd1,   1'b1, 1'b0, '0},
        '{CMD_WRITE, 7'd127, 7'd120, 8'd2,   8'd1,   1'b1, 1'b0, '0},
        '{CMD_QUERY, 7'd0,   7'd0,   8'd128, 8'd128, 1'b0, 1'b0, '0},
        '{CMD_QUERY, 7'd120, 7'd120, 8'd8,   8'd8,   1'b0, 1'b0, '0},
        '{CMD_CLEAR, 7'd5,   7'd5,   8'd1,   8'd1,   1'b1, 1'b0, '0},
        '{CMD_QUERY, 7'd0,   7'd0,   8'd128, 8'd128, 1'b0, 1'b1, '{1'b1, 15'd0, 1'b1}}
    };

    int phase_w[] = '{1, 0, 16, 255, 7, 128};
    int phase_h[] = '{1, 255, 16, 0, 12, 128};

    initial begin
        start      <= 1'b0;
        i_rst_n    <= 1'b0;
        i_cmd      <= CMD_NONE;
        i_col      <= '0;
        i_row      <= '0;
        i_rect_w   <= '0;
        i_rect_h   <= '0;
        i_occupied <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= '0;
        mismatches = 0;
        no_gaps    = 1'b0;
        width_reg  = 8'd128;
        height_reg = 8'd128;
        wipe_stores();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset grid size
        foreach (directed[i])
            issue(directed[i].cmd, directed[i].col, directed[i].row, directed[i].rw,
                  directed[i].rh, directed[i].occ, directed[i].typed, directed[i].want);
        settle();

        // Random phases, each under a new grid size
        foreach (phase_w[p]) begin
            write_reg(REG_WIDTH, 8'(phase_w[p]));
            write_reg(REG_HEIGHT, 8'(phase_h[p]));
            no_gaps = p[0];
            random_phase(330);
            settle();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
